// File: src/rib_pkg.sv
// Shared types and constants for the rotated image blit address generator.
// Used by rib_front, rib_fifo, rib_back and the core top level.
package rib_pkg;

  localparam int unsigned SCREEN_WIDTH  = 1024;
  localparam int unsigned SCREEN_HEIGHT = 512;
  localparam int unsigned PIX_X_W       = $clog2(SCREEN_WIDTH);
  localparam int unsigned PIX_Y_W       = $clog2(SCREEN_HEIGHT);

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned TGT_W    = COORD_W + 2;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE     = 3'd5;

  localparam logic [1:0] PHASE_LAST_3B = 2'd2;
  localparam logic [1:0] PHASE_LAST_4B = 2'd3;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] source_width;
    logic [COORD_W-1:0] source_height;
    rot_e               rotation;
    logic               four_byte_pixels;
  } cfg_t;

  // One completed source pixel on its way from front to back.
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// File: src/rotated_image_blit_address_gen_core.sv
// Rotated image blit address generator: bytes in, one framebuffer write word per pixel.
// A pixel's word passes through the pixel queue and then the output register after its last byte is taken.
// Throughput: one byte per cycle while the pixel queue is not full, set by the front's byte packer and counter update.
// The two-entry pixel queue and the output register let either side stall on its own.
// Reset (async, active low) clears counters, queue and output valid; registers get
// their reset values: origin 0/0, size 1x1, no rotation, three bytes per pixel.
module rotated_image_blit_address_gen_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rib_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rib_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // byte input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          pixel_byte_i,
  input  logic                                restart_i,
  // write word output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                write_enable_o,
  output logic [rib_pkg::PIX_X_W-1:0]         pixel_x_o,
  output logic [rib_pkg::PIX_Y_W-1:0]         pixel_y_o,
  output logic [rib_pkg::COLOR_W-1:0]         pixel_color_o,
  output logic                                last_pixel_o
);

  rib_pkg::cfg_t          cfg_q;
  rib_pkg::pix_t          front_pix, head_pix;
  rib_pkg::fifo_status_t  fifo_status;
  logic                   in_accept;
  logic                   fifo_push;
  logic                   fifo_pop;

  // Configuration registers: plain write, no read-back; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x         <= '0;
      cfg_q.origin_y         <= '0;
      cfg_q.source_width     <= rib_pkg::COORD_W'(1);
      cfg_q.source_height    <= rib_pkg::COORD_W'(1);
      cfg_q.rotation         <= rib_pkg::ROT_0;
      cfg_q.four_byte_pixels <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rib_pkg::CFG_ORIGIN_X:      cfg_q.origin_x <= cfg_wdata_i;
        rib_pkg::CFG_ORIGIN_Y:      cfg_q.origin_y <= cfg_wdata_i;
        rib_pkg::CFG_SOURCE_WIDTH:  cfg_q.source_width <= cfg_wdata_i;
        rib_pkg::CFG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_wdata_i;
        rib_pkg::CFG_ROTATION:      cfg_q.rotation <= rib_pkg::rot_e'(cfg_wdata_i[1:0]);
        rib_pkg::CFG_FOUR_BYTE:     cfg_q.four_byte_pixels <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Hold the input only while the pixel queue is full; the front itself never waits.
  assign in_stall_o = fifo_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Front: pack bytes, advance the source counters, emit a pixel on its final byte.
  rib_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (in_accept),
    .pixel_byte_i (pixel_byte_i),
    .restart_i    (restart_i),
    .push_o       (fifo_push),
    .pix_o        (front_pix)
  );

  // Queue: decouple byte intake from output backpressure.
  rib_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .pix_i    (front_pix),
    .pop_i    (fifo_pop),
    .pix_o    (head_pix),
    .status_o (fifo_status)
  );

  // Back: rotate, place at origin, clip and register the write word.
  rib_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pix_i          (head_pix),
    .avail_i        (!fifo_status.empty),
    .pop_o          (fifo_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_pixel_o   (last_pixel_o)
  );

`ifndef ASSERT_OFF
  // A clipped write carries zero coordinates.
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> pixel_x_o == '0 && pixel_y_o == '0)
    else $error("clipped write with nonzero coordinates");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_status.full)
    else $error("pixel queue overflow");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_status.empty)
    else $error("pixel queue underflow");
`endif

endmodule

// File: src/rib_front.sv
// Front end: packs bytes into colors and walks the source column/row counters.
// Depends on rib_pkg.
module rib_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rib_pkg::cfg_t        cfg_i,
  input  logic                 accept_i,
  input  logic [7:0]           pixel_byte_i,
  input  logic                 restart_i,
  output logic                 push_o,
  output rib_pkg::pix_t        pix_o
);

  logic [1:0]                   phase_q, phase_d, phase_cur;
  logic [23:0]                  partial_q, partial_d, partial_cur;
  logic [rib_pkg::COORD_W-1:0]  col_q, col_d, col_cur;
  logic [rib_pkg::COORD_W-1:0]  row_q, row_d, row_cur;
  logic [1:0]                   last_phase;
  logic                         done;
  logic                         col_end, row_end;
  logic [rib_pkg::COLOR_W-1:0]  color;

  always_comb begin
    phase_cur   = restart_i ? 2'd0 : phase_q;
    partial_cur = restart_i ? 24'd0 : partial_q;
    col_cur     = restart_i ? '0 : col_q;
    row_cur     = restart_i ? '0 : row_q;
    last_phase  = cfg_i.four_byte_pixels ? rib_pkg::PHASE_LAST_4B : rib_pkg::PHASE_LAST_3B;
    done        = phase_cur >= last_phase;

    color = {partial_cur, pixel_byte_i};
    if (!cfg_i.four_byte_pixels) begin
      color[31:24] = 8'd0;
    end

    // x >= w - 1 written as x + 1 >= w, which also covers zero size
    col_end = ({1'b0, col_cur} + 13'd1) >= {1'b0, cfg_i.source_width};
    row_end = ({1'b0, row_cur} + 13'd1) >= {1'b0, cfg_i.source_height};

    phase_d   = phase_q;
    partial_d = partial_q;
    col_d     = col_q;
    row_d     = row_q;
    if (accept_i) begin
      if (!done) begin
        phase_d   = phase_cur + 2'd1;
        partial_d = {partial_cur[15:0], pixel_byte_i};
        col_d     = col_cur;
        row_d     = row_cur;
      end else begin
        phase_d   = 2'd0;
        partial_d = 24'd0;
        if (col_end) begin
          col_d = '0;
          row_d = row_end ? '0 : row_cur + 1'b1;
        end else begin
          col_d = col_cur + 1'b1;
          row_d = row_cur;
        end
      end
    end

    push_o       = accept_i && done;
    pix_o.column = col_cur;
    pix_o.row    = row_cur;
    pix_o.color  = color;
    pix_o.last   = col_end && row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 2'd0;
      partial_q <= 24'd0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

endmodule

// File: src/rib_fifo.sv
// Short queue of completed pixels between front and back.
// Depends on rib_pkg.
module rib_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rib_pkg::pix_t         pix_i,
  input  logic                  pop_i,
  output rib_pkg::pix_t         pix_o,
  output rib_pkg::fifo_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(rib_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(rib_pkg::FIFO_DEPTH + 1);

  rib_pkg::pix_t     mem_q [rib_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(rib_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(rib_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign pix_o          = mem_q[rd_ptr_q];
  assign status_o.full  = count_q == CNT_W'(rib_pkg::FIFO_DEPTH);
  assign status_o.empty = count_q == '0;

endmodule

// File: src/rib_back.sv
// Back end: rotates and places each pixel, clips it, holds the result word.
// Depends on rib_pkg.
module rib_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rib_pkg::cfg_t                 cfg_i,
  input  rib_pkg::pix_t                 pix_i,
  input  logic                          avail_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          write_enable_o,
  output logic [rib_pkg::PIX_X_W-1:0]   pixel_x_o,
  output logic [rib_pkg::PIX_Y_W-1:0]   pixel_y_o,
  output logic [rib_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic                          last_pixel_o
);

  localparam int unsigned TW = rib_pkg::TGT_W;

  logic signed [TW-1:0]          ox, oy, xs, ys, ws, hs, tx, ty;
  logic                          on;
  logic                          valid_q;
  logic                          we_q;
  logic [rib_pkg::PIX_X_W-1:0]   x_q;
  logic [rib_pkg::PIX_Y_W-1:0]   y_q;
  logic [rib_pkg::COLOR_W-1:0]   color_q;
  logic                          last_q;

  always_comb begin
    ox = signed'({2'b00, cfg_i.origin_x});
    oy = signed'({2'b00, cfg_i.origin_y});
    xs = signed'({2'b00, pix_i.column});
    ys = signed'({2'b00, pix_i.row});
    ws = signed'({2'b00, cfg_i.source_width});
    hs = signed'({2'b00, cfg_i.source_height});
    case (cfg_i.rotation)
      rib_pkg::ROT_90: begin
        tx = ox + ys;
        ty = oy + ws - xs - TW'(1);
      end
      rib_pkg::ROT_180: begin
        tx = ox + ws - xs - TW'(1);
        ty = oy + hs - ys - TW'(1);
      end
      rib_pkg::ROT_270: begin
        tx = ox + hs - ys - TW'(1);
        ty = oy + xs;
      end
      default: begin
        tx = ox + xs;
        ty = oy + ys;
      end
    endcase
    on = !tx[TW-1] && !ty[TW-1]
      && (tx < signed'(TW'(rib_pkg::SCREEN_WIDTH)))
      && (ty < signed'(TW'(rib_pkg::SCREEN_HEIGHT)));
  end

  // advance when the output register is free or being taken this cycle
  assign pop_o = avail_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      we_q    <= on;
      x_q     <= on ? tx[rib_pkg::PIX_X_W-1:0] : '0;
      y_q     <= on ? ty[rib_pkg::PIX_Y_W-1:0] : '0;
      color_q <= pix_i.color;
      last_q  <= pix_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign write_enable_o = we_q;
  assign pixel_x_o      = x_q;
  assign pixel_y_o      = y_q;
  assign pixel_color_o  = color_q;
  assign last_pixel_o   = last_q;

endmodule
